FILE: hdl/utf8d_pkg.sv
// package: item types, status codes and byte classification for the utf-8 decoder
package utf8d_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int CPW = 36;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_STRAY = 2'd1;
	localparam logic [1:0] ST_LEAD_FF = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [3:0] ONES_ASCII = 4'd0;
	localparam logic [3:0] ONES_CONT = 4'd1;
	localparam logic [3:0] ONES_FF = 4'd8;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [CPW-1:0] code_point;
		logic [1:0]     status;
	} out_item_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] ones;
		logic [6:0] lead_bits;
		logic       last;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic run;
		n = '0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

	function automatic logic [6:0] lead_payload(input logic [7:0] b, input logic [3:0] n);
		logic [6:0] m;
		m = 7'h7f >> n;
		return b[6:0] & m;
	endfunction

endpackage

FILE: hdl/utf8d_front.sv
// front stage: accepts request bytes and classifies the lead bits
module utf8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  utf8d_pkg::in_item_t item,
	input  utf8d_pkg::q_stat_t  q_stat,
	output logic                q_wr,
	output utf8d_pkg::cls_t     q_data
);
	import utf8d_pkg::*;

	logic vld_s1;
	cls_t cls_s1;
	logic take;

	assign q_wr = vld_s1 && !q_stat.full;
	assign full = vld_s1 && q_stat.full;
	assign take = push && !full;
	assign q_data = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1.byte_value <= item.byte_value;
			cls_s1.ones <= lead_ones(item.byte_value);
			cls_s1.lead_bits <= lead_payload(item.byte_value, lead_ones(item.byte_value));
			cls_s1.last <= item.end_of_string;
		end
	end

endmodule

FILE: hdl/utf8d_queue.sv
// short queue of classified bytes between front and back
module utf8d_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  utf8d_pkg::cls_t    wr_data,
	input  logic               rd,
	output utf8d_pkg::cls_t    rd_data,
	output utf8d_pkg::q_stat_t stat
);
	import utf8d_pkg::*;

	cls_t mem [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign stat.full = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr = wr && !stat.full;
	assign do_rd = rd && !stat.empty;
	assign rd_data = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wr_data;
		end
	end

endmodule

FILE: hdl/utf8d_back.sv
// back stage: sequence accumulation and two-entry result buffer
module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::cls_t      q_data,
	input  utf8d_pkg::q_stat_t   q_stat,
	output logic                 q_rd,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t result
);
	import utf8d_pkg::*;

	logic [CPW-1:0] acc_q;
	logic [2:0] rem_q;
	out_item_t obuf [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] ocnt_q;

	logic pop_fire;
	logic go;
	logic emit;
	out_item_t res;
	logic [CPW-1:0] acc_n;
	logic [2:0] rem_n;
	logic [CPW-1:0] shifted;

	assign empty = (ocnt_q == 2'd0);
	assign pop_fire = pop && !empty;
	assign go = !q_stat.empty && (ocnt_q != 2'd2 || pop_fire);
	assign q_rd = go;
	assign result = obuf[rptr_q];
	assign shifted = {acc_q[CPW-7:0], q_data.byte_value[5:0]};

	always_comb begin
		emit = 1'b0;
		res.code_point = '0;
		res.status = ST_OK;
		acc_n = acc_q;
		rem_n = rem_q;
		if (rem_q != 3'd0) begin
			acc_n = shifted;
			rem_n = rem_q - 3'd1;
			if (rem_n == 3'd0) begin
				emit = 1'b1;
				res.code_point = shifted;
			end else if (q_data.last) begin
				emit = 1'b1;
				res.status = ST_TRUNC;
			end
		end else begin
			unique case (q_data.ones)
				ONES_ASCII: begin
					emit = 1'b1;
					res.code_point = CPW'(q_data.lead_bits);
				end
				ONES_CONT: begin
					emit = 1'b1;
					res.status = ST_STRAY;
				end
				ONES_FF: begin
					emit = 1'b1;
					res.status = ST_LEAD_FF;
				end
				default: begin
					acc_n = CPW'(q_data.lead_bits);
					rem_n = 3'(q_data.ones - 4'd1);
					if (q_data.last) begin
						emit = 1'b1;
						res.status = ST_TRUNC;
					end
				end
			endcase
		end
		if (emit) begin
			acc_n = '0;
			rem_n = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= 3'd0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (go) begin
				acc_q <= acc_n;
				rem_q <= rem_n;
			end
			if (go && emit) begin
				wptr_q <= ~wptr_q;
			end
			if (pop_fire) begin
				rptr_q <= ~rptr_q;
			end
			ocnt_q <= ocnt_q + 2'(go && emit) - 2'(pop_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			obuf[wptr_q] <= res;
		end
	end

	a_ocnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result buffer overflow");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && emit |=> rem_q == 3'd0 && acc_q == '0)
		else $error("state not cleared after result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		go && emit && res.status != ST_OK |-> res.code_point == '0)
		else $error("error result with nonzero code point");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && q_data.last |=> rem_q == 3'd0)
		else $error("sequence open after end of string");

endmodule

FILE: hdl/utf8_byte_stream_decoder.sv
// top level: utf-8 byte stream decoder, up to seven-byte sequences
//
// usage:
//   input queue side: drive item (byte and end-of-string flag) with push;
//   a request is taken at a rising edge with push high and full low.
//   result queue side: while empty is low, result holds the oldest code
//   point and status; pop high at a rising edge takes it.
//   a lead byte opens a sequence; one result comes when it completes, and
//   one error result (code point zero) on a stray continuation, a 0xff
//   lead, or a sequence cut short by end of string.
// path: a result passes the front register, byte queue and result buffer.
// throughput: one byte per cycle unless a stalled pop holds back the flow.
// stall: a stalled pop fills the two-entry result buffer, then the
//   four-entry byte queue, then the front stage; full rises only then.
// reset: arst_n clears all queues and any open sequence.
module utf8_byte_stream_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  utf8d_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t result
);
	import utf8d_pkg::*;

	q_stat_t q_stat;
	logic q_wr;
	logic q_rd;
	cls_t q_wdata;
	cls_t q_rdata;

	utf8d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_stat (q_stat),
		.q_wr   (q_wr),
		.q_data (q_wdata)
	);

	utf8d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.stat    (q_stat)
	);

	utf8d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (q_rdata),
		.q_stat (q_stat),
		.q_rd   (q_rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
